// ----- rtl/mct_pkg.sv -----
// Package for the multi-click toggle button detector.
// Holds the state and event codes, register indexes, reset values and shared structs.
// No dependencies.
package mct_pkg;

  localparam int unsigned MaxClicks = 10;

  localparam logic [7:0] MAX_CLICKS = 8'(MaxClicks);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PRESSED = 3'd1,
    MODE_WAIT    = 3'd2,
    MODE_TOGGLED = 3'd3,
    MODE_TOG_REL = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_TOGGLE = 2'd2
  } ev_kind_e;

  typedef enum logic [2:0] {
    REG_ACTIVE_LOW    = 3'd0,
    REG_DEBOUNCE_MS   = 3'd1,
    REG_CLICK_MS      = 3'd2,
    REG_TOGGLE_MS     = 3'd3,
    REG_TOGGLE_ENABLE = 3'd4
  } reg_idx_e;

  localparam logic        RST_ACTIVE_LOW    = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd50;
  localparam logic [15:0] RST_CLICK_MS      = 16'd400;
  localparam logic [15:0] RST_TOGGLE_MS     = 16'd400;
  localparam logic        RST_TOGGLE_ENABLE = 1'b0;

  typedef struct packed {
    logic        active_low;
    logic [15:0] debounce_ms;
    logic [15:0] click_ms;
    logic [15:0] toggle_ms;
    logic        toggle_enable;
  } cfg_t;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    ev_kind_e   event_kind;
    logic [3:0] click_count;
  } result_t;

endpackage

// ----- rtl/mct_if.sv -----
// Valid/ready channel interfaces for button samples and detector events.
// No dependencies.
interface mct_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface mct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [3:0] click_count;

  modport source (output valid, output event_kind, output click_count, input ready);
  modport sink   (input valid, input event_kind, input click_count, output ready);
endinterface

// ----- rtl/multi_click_toggle_button.sv -----
// Top level of the multi-click toggle button detector.
// Depends on mct_pkg, mct_if, mct_cfg_regs and mct_core.
//
// The block takes one button sample request (pin level and millisecond timestamp) per
// clock while its output is not stalled and returns exactly one event request for each:
// none, a finished click sequence with its count, or a toggle. A sample is captured in
// an input register, stepped through the detector state machine when the result register
// can advance, and held in it. The sustained rate is one sample per cycle while the output
// is not stalled, set by the single state update per cycle. A stalled result register
// holds the input side only once the input register is also full. Configuration writes
// are taken at any time but should be made only while no sample is in flight.
module multi_click_toggle_button (
  input  logic        clk_i,
  input  logic        rst_ni,
  mct_in_if.sink      in_ch,
  mct_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import mct_pkg::*;

  cfg_t    cfg;
  sample_t sample_q;
  result_t step_result;
  result_t result_q;
  logic    in_vld_q;
  logic    out_vld_q;
  logic    advance;
  logic    step;
  logic    in_take;

  assign advance = !out_vld_q || out_ch.ready;
  assign step    = in_vld_q && advance;
  assign in_ch.ready = !in_vld_q || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  mct_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .sample_i (sample_q),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q.pin_level <= in_ch.pin_level;
      sample_q.now_ms    <= in_ch.now_ms;
    end
    if (step) begin
      result_q <= step_result;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.event_kind  = result_q.event_kind;
  assign out_ch.click_count = result_q.click_count;

  // A stepped sample always lands in the result register.
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped sample did not reach the result register");

  // A click event always carries a non-zero count.
  a_click_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && result_q.event_kind == EV_CLICK) |-> (result_q.click_count != 4'd0))
    else $error("click event with zero count");

  // Non-click events carry no count.
  a_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && result_q.event_kind != EV_CLICK) |-> (result_q.click_count == 4'd0))
    else $error("count on a non-click event");

  // The input register is never overwritten while it holds an unstepped sample.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |-> !in_take)
    else $error("input register overrun");

endmodule

// ----- rtl/mct_cfg_regs.sv -----
// Configuration register bank of the button detector.
// Depends on mct_pkg.
module mct_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output mct_pkg::cfg_t      cfg_o
);
  import mct_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACTIVE_LOW:    cfg_d.active_low    = cfg_data_i[0];
        REG_DEBOUNCE_MS:   cfg_d.debounce_ms   = cfg_data_i;
        REG_CLICK_MS:      cfg_d.click_ms      = cfg_data_i;
        REG_TOGGLE_MS:     cfg_d.toggle_ms     = cfg_data_i;
        REG_TOGGLE_ENABLE: cfg_d.toggle_enable = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low    <= RST_ACTIVE_LOW;
      cfg_q.debounce_ms   <= RST_DEBOUNCE_MS;
      cfg_q.click_ms      <= RST_CLICK_MS;
      cfg_q.toggle_ms     <= RST_TOGGLE_MS;
      cfg_q.toggle_enable <= RST_TOGGLE_ENABLE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/mct_core.sv -----
// Press/click/toggle state machine: state registers plus the per-sample step logic.
// Depends on mct_pkg.
module mct_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mct_pkg::cfg_t     cfg_i,
  input  logic              step_i,
  input  mct_pkg::sample_t  sample_i,
  output mct_pkg::result_t  result_o
);
  import mct_pkg::*;

  mode_e       mode_q, mode_d;
  mode_e       prior_q, prior_d;
  logic [31:0] stamp_q, stamp_d;
  logic [7:0]  tally_q, tally_d;

  logic        pressed;
  logic [31:0] elapsed;
  logic        lt_debounce, lt_click, gt_click, lt_toggle, gt_toggle;
  logic        seq_reportable;

  assign pressed     = cfg_i.active_low ? ~sample_i.pin_level : sample_i.pin_level;
  assign elapsed     = sample_i.now_ms - stamp_q;
  assign lt_debounce = elapsed < {16'd0, cfg_i.debounce_ms};
  assign lt_click    = elapsed < {16'd0, cfg_i.click_ms};
  assign gt_click    = elapsed > {16'd0, cfg_i.click_ms};
  assign lt_toggle   = elapsed < {16'd0, cfg_i.toggle_ms};
  assign gt_toggle   = elapsed > {16'd0, cfg_i.toggle_ms};

  // A finished sequence is reported only for a tally of one up to the limit.
  assign seq_reportable = (tally_q != 8'd0) && (tally_q <= MAX_CLICKS);

  // Next state
  always_comb begin
    mode_d  = mode_q;
    prior_d = prior_q;
    stamp_d = stamp_q;
    tally_d = tally_q;
    if (step_i) begin
      unique case (mode_q)
        MODE_IDLE: begin
          if (pressed) begin
            mode_d  = MODE_PRESSED;
            prior_d = mode_q;
            stamp_d = sample_i.now_ms;
          end
        end
        MODE_PRESSED: begin
          if (!pressed) begin
            if (lt_debounce) begin
              // Bounce: fall back to wherever the press came from.
              mode_d  = prior_q;
              prior_d = mode_q;
            end else if (lt_click) begin
              tally_d = tally_q + 8'd1;
              mode_d  = MODE_WAIT;
              prior_d = mode_q;
              stamp_d = sample_i.now_ms;
            end else begin
              mode_d  = MODE_IDLE;
              prior_d = mode_q;
              tally_d = 8'd0;
            end
          end else if (cfg_i.toggle_enable && gt_toggle) begin
            mode_d  = MODE_TOGGLED;
            prior_d = mode_q;
            stamp_d = sample_i.now_ms;
          end
        end
        MODE_WAIT: begin
          if (gt_click) begin
            mode_d  = MODE_IDLE;
            prior_d = mode_q;
            tally_d = 8'd0;
          end else if (pressed) begin
            mode_d  = MODE_PRESSED;
            prior_d = mode_q;
            stamp_d = sample_i.now_ms;
          end
        end
        MODE_TOGGLED: begin
          if (!pressed) begin
            mode_d  = MODE_TOG_REL;
            prior_d = mode_q;
            stamp_d = sample_i.now_ms;
          end
        end
        MODE_TOG_REL: begin
          if (pressed) begin
            if (lt_toggle) begin
              mode_d  = prior_q;
              prior_d = mode_q;
            end
          end else if (gt_toggle) begin
            // The hold timer is deliberately not restarted here.
            mode_d  = MODE_PRESSED;
            prior_d = mode_q;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          prior_d = mode_q;
        end
      endcase
    end
  end

  // Event outputs
  always_comb begin
    result_o.event_kind  = EV_NONE;
    result_o.click_count = 4'd0;
    unique case (mode_q)
      MODE_PRESSED: begin
        if (!pressed) begin
          if (!lt_debounce && !lt_click && seq_reportable) begin
            result_o.event_kind  = EV_CLICK;
            result_o.click_count = tally_q[3:0];
          end
        end else if (cfg_i.toggle_enable && gt_toggle) begin
          result_o.event_kind = EV_TOGGLE;
        end
      end
      MODE_WAIT: begin
        if (gt_click && seq_reportable) begin
          result_o.event_kind  = EV_CLICK;
          result_o.click_count = tally_q[3:0];
        end
      end
      MODE_TOG_REL: begin
        if (!pressed && gt_toggle) begin
          result_o.event_kind = EV_TOGGLE;
        end
      end
      default: begin
        result_o.event_kind  = EV_NONE;
        result_o.click_count = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      prior_q <= MODE_IDLE;
      stamp_q <= 32'd0;
      tally_q <= 8'd0;
    end else begin
      mode_q  <= mode_d;
      prior_q <= prior_d;
      stamp_q <= stamp_d;
      tally_q <= tally_d;
    end
  end

endmodule
